// File: rtl/core/idiv64_pkg.sv
// shared types and constants of the 64-bit integer divider
package idiv64_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int FIELD_W        = 64;

    typedef enum logic [1:0] {
        OP_UQUO = 2'd0,
        OP_SQUO = 2'd1,
        OP_UREM = 2'd2,
        OP_RSVD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_ctrl;

endpackage

// File: rtl/core/idiv64_datapath.sv
// shift-subtract datapath: operand magnitudes, remainder and quotient registers
module idiv64_datapath import idiv64_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_ctrl                 i_ctrl,
    input  logic [1:0]            i_operation,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_zero,
    output logic [DATA_WIDTH-1:0] o_result
);

    t_op                   r_op;
    logic                  r_neg;
    logic                  r_zero;
    logic [DATA_WIDTH-1:0] r_dvs;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;

    t_op                   in_op;
    logic                  a_neg;
    logic                  d_neg;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] d_mag;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH-1:0] diff;
    logic                  ge;
    logic [DATA_WIDTH-1:0] n_rem;

    // operand magnitudes for signed division
    always_comb begin
        in_op = t_op'(i_operation);
        a_neg = (in_op == OP_SQUO) && i_dividend[DATA_WIDTH-1];
        d_neg = (in_op == OP_SQUO) && i_divisor[DATA_WIDTH-1];
        a_mag = a_neg ? (~i_dividend + 1'b1) : i_dividend;
        d_mag = d_neg ? (~i_divisor + 1'b1) : i_divisor;
    end

    // one restoring step: the bit shifted out of the remainder counts as carry
    always_comb begin
        shifted = {r_rem, r_quo[DATA_WIDTH-1]};
        diff    = shifted[DATA_WIDTH-1:0] - r_dvs;
        ge      = (shifted >= {1'b0, r_dvs});
        n_rem   = ge ? diff : shifted[DATA_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op   <= in_op;
            r_neg  <= a_neg ^ d_neg;
            r_zero <= (i_divisor == '0);
            r_dvs  <= d_mag;
            r_rem  <= '0;
            r_quo  <= a_mag;
        end else if (i_ctrl.step) begin
            r_rem  <= n_rem;
            r_quo  <= {r_quo[DATA_WIDTH-2:0], ge};
        end
    end

    // sign fixup and selection; on a zero divisor r_quo still holds the dividend magnitude
    always_comb begin
        o_zero = r_zero;
        if (r_zero) begin
            o_result = (r_op == OP_UREM) ? r_quo : '0;
        end else begin
            unique case (r_op)
                OP_SQUO: o_result = r_neg ? (~r_quo + 1'b1) : r_quo;
                OP_UREM: o_result = r_rem;
                default: o_result = r_quo;
            endcase
        end
    end

endmodule

// File: rtl/core/idiv64_ctrl.sv
// sequencer: accepts an item, counts the division steps, hands off the result
module idiv64_ctrl import idiv64_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_zero,
    input  logic  i_out_busy,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    localparam int CW = $clog2(DATA_WIDTH);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // no item is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_ctrl.load = 1'b1;
                    n_cnt       = CW'(DATA_WIDTH - 1);
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_zero) begin
                    n_state = ST_FIX;
                end else begin
                    o_ctrl.step = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = ST_FIX;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ST_FIX: begin
                if (!i_out_busy) begin
                    o_ctrl.fix = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/core/integer_divider_64.sv
// top level of the iterative 64-bit integer divider
// after an accept the subtract loop makes one quotient bit per cycle, then the result moves to
//   the output register that drives o_valid; a zero divisor skips the loop
// a new item is accepted only after the previous result has left the loop
// o_ready is low while an item is in the loop or waits for hand-off; a result waiting
//   in the output register does not block the next accept, only the next hand-off
// reset (synchronous, active low) empties the sequencer and the output register
module integer_divider_64 import idiv64_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [FIELD_W-1:0] i_dividend,
    input  logic [FIELD_W-1:0] i_divisor,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FIELD_W-1:0] o_quotient_or_rest,
    output logic               o_zero_divisor
);

    t_ctrl                 ctrl;
    logic                  zero;
    logic                  out_busy;
    logic [DATA_WIDTH-1:0] result;

    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_data;
    logic                  r_out_zero;

    // output register holds a result until the consumer takes it
    assign out_busy = r_out_valid && !i_ready;

    idiv64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_zero     (zero),
        .i_out_busy (out_busy),
        .o_in_ready (o_ready),
        .o_ctrl     (ctrl)
    );

    // only the low DATA_WIDTH bits of the operands take part
    idiv64_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_operation (i_operation),
        .i_dividend  (i_dividend[DATA_WIDTH-1:0]),
        .i_divisor   (i_divisor[DATA_WIDTH-1:0]),
        .o_zero      (zero),
        .o_result    (result)
    );

    // valid flag of the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fix) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, upper bits zero when the datapath is narrower than the port
    always_ff @(posedge i_clk) begin
        if (ctrl.fix) begin
            r_out_data <= FIELD_W'(result);
            r_out_zero <= zero;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_quotient_or_rest = r_out_data;
    assign o_zero_divisor     = r_out_zero;

endmodule

// File: rtl/core/idiv64_chk.sv
// port-level checker for the integer divider, bound to the top level
module idiv64_chk import idiv64_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [FIELD_W-1:0] o_quotient_or_rest,
    input logic               o_zero_divisor
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quotient_or_rest)
            && $stable(o_zero_divisor))
        else $error("result changed while stalled");

    // the unit is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

    // no result can appear in the cycle after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result too early");

    // bits above the datapath width stay zero
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_quotient_or_rest >> DATA_WIDTH) == '0))
        else $error("result upper bits set");

endmodule

bind integer_divider_64 idiv64_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_idiv64_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_quotient_or_rest (o_quotient_or_rest),
    .o_zero_divisor     (o_zero_divisor)
);

// File: tb/sv/integer_divider_64_check.sv
// checker for the 64-bit integer divider: predicts each result and compares it
module integer_divider_64_check import idiv64_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [FIELD_W-1:0] i_dividend,
    input  logic [FIELD_W-1:0] i_divisor,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [FIELD_W-1:0] o_quotient_or_rest,
    input  logic               o_zero_divisor,
    output int                 o_fail_cnt,
    output int                 o_pending,
    output int                 o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FIELD_W-1:0] WORD_MASK = {FIELD_W{1'b1}} >> (FIELD_W - DATA_WIDTH);
    localparam logic [FIELD_W-1:0] SIGN_BIT  = {{(FIELD_W-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic               zero_div;
    } t_answer;

    t_answer answer_q[$];

    // quotient or remainder of one item, truncating toward zero
    function automatic t_answer divide_item(t_op op, logic [FIELD_W-1:0] dividend,
                                            logic [FIELD_W-1:0] divisor);
        logic [FIELD_W-1:0] num;
        logic [FIELD_W-1:0] den;
        logic [FIELD_W-1:0] quo;
        logic               flip;
        t_answer            ans;
        num  = dividend & WORD_MASK;
        den  = divisor & WORD_MASK;
        flip = 1'b0;
        ans  = '0;
        if (den == '0) begin
            ans.value    = (op == OP_UREM) ? num : '0;
            ans.zero_div = 1'b1;
            return ans;
        end
        case (op)
            OP_SQUO: begin
                // divide the magnitudes, negate when the signs differ
                if ((num & SIGN_BIT) != '0) begin
                    num  = (-num) & WORD_MASK;
                    flip = ~flip;
                end
                if ((den & SIGN_BIT) != '0) begin
                    den  = (-den) & WORD_MASK;
                    flip = ~flip;
                end
                quo       = num / den;
                ans.value = flip ? ((-quo) & WORD_MASK) : quo;
            end
            OP_UREM: ans.value = num % den;
            default: ans.value = num / den;
        endcase
        return ans;
    endfunction

    initial begin
        o_fail_cnt = 0;
        o_checked  = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_answer exp_ans;
        int      errs;
        errs = 0;
        if (i_rst_n) begin
            // hand-off first: a result leaving now belongs to an older item
            if (o_valid && i_ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: result %h/%b with no item outstanding",
                             $time, o_quotient_or_rest, o_zero_divisor);
                    errs = errs + 1;
                end else begin
                    exp_ans = answer_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (o_quotient_or_rest !== exp_ans.value) begin
                        $display("%0t: quotient_or_rest expected %h, actual %h",
                                 $time, exp_ans.value, o_quotient_or_rest);
                        errs = errs + 1;
                    end
                    if (o_zero_divisor !== exp_ans.zero_div) begin
                        $display("%0t: zero_divisor expected %b, actual %b",
                                 $time, exp_ans.zero_div, o_zero_divisor);
                        errs = errs + 1;
                    end
                end
            end
            if (i_valid && o_ready) begin
                answer_q.push_back(divide_item(t_op'(i_operation), i_dividend, i_divisor));
            end
        end
        o_fail_cnt <= o_fail_cnt + errs;
        o_pending  <= answer_q.size();
    end

endmodule

// File: tb/sv/integer_divider_64_test.sv
// top of the integer divider testbench: stimulus, back-pressure and verdict
module integer_divider_64_test;

    timeunit 1ns;
    timeprecision 1ps;

    import idiv64_pkg::*;

    localparam int DATA_WIDTH    = DATA_WIDTH_DEF;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_LEN      = 600;
    localparam int RANDOM_PER_PH = 160;

    localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};
    localparam logic [FIELD_W-1:0] MIN_NEG  = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [FIELD_W-1:0] MAX_POS  = {1'b0, {(FIELD_W-1){1'b1}}};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_operation;
    logic [FIELD_W-1:0] i_dividend;
    logic [FIELD_W-1:0] i_divisor;
    logic               o_valid;
    logic               i_ready;
    logic [FIELD_W-1:0] o_quotient_or_rest;
    logic               o_zero_divisor;

    int fail_cnt;
    int pending;
    int checked;

    // idle percentages per side, changed between phases
    int tx_idle_pct;
    int rx_idle_pct;

    // hold-off handshake between the stimulus and the receiver process
    int hold_req;
    int hold_done;
    int hold_left;

    // what was sent, for the closing summary
    int items_sent;
    int zero_div_sent;
    int op_sent[4];
    int cycles;

    integer_divider_64 #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_dividend         (i_dividend),
        .i_divisor          (i_divisor),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_quotient_or_rest (o_quotient_or_rest),
        .o_zero_divisor     (o_zero_divisor)
    );

    // watches both channels, predicts every result and counts mismatches
    integer_divider_64_check #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_dividend         (i_dividend),
        .i_divisor          (i_divisor),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_quotient_or_rest (o_quotient_or_rest),
        .o_zero_divisor     (o_zero_divisor),
        .o_fail_cnt         (fail_cnt),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side: random stalls, or a long hold-off when one is requested
    initial begin
        i_ready   = 1'b0;
        hold_done = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_req != hold_done) begin
                // block keeps accepting until its loop and output register are both busy
                hold_done = hold_req;
                hold_left = HOLD_LEN - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on the whole run
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles = cycles + 1;
        end
        $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
        $display("Simulation FAILED");
        $finish;
    end

    // random operand with a spread of magnitudes and signs
    function automatic logic [FIELD_W-1:0] pick_operand();
        logic [FIELD_W-1:0] val;
        val = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4:    val = val >> $urandom_range(0, FIELD_W - 1);
            5:       val = FIELD_W'($urandom_range(0, 16));
            6:       val = -FIELD_W'($urandom_range(1, 16));
            7: begin
                case ($urandom_range(0, 5))
                    0:       val = '0;
                    1:       val = FIELD_W'(1);
                    2:       val = ALL_ONES;
                    3:       val = MIN_NEG;
                    4:       val = MAX_POS;
                    default: val = ALL_ONES - FIELD_W'(1);
                endcase
            end
            default: begin
                val = val >> $urandom_range(0, FIELD_W - 1);
                if ($urandom_range(0, 1) == 1) val = -val;
            end
        endcase
        return val;
    endfunction

    // offer one item: random idle cycles first, then hold valid until accepted
    task automatic offer_division(t_op op, logic [FIELD_W-1:0] dividend,
                                  logic [FIELD_W-1:0] divisor);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            // payload wanders while valid is low
            i_valid     <= 1'b0;
            i_operation <= 2'($urandom_range(0, 3));
            i_dividend  <= {$urandom, $urandom};
            i_divisor   <= {$urandom, $urandom};
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_dividend  <= dividend;
        i_divisor   <= divisor;
        do begin
            @(posedge i_clk);
        end while (!(i_valid && o_ready));
        items_sent = items_sent + 1;
        op_sent[op] = op_sent[op] + 1;
        if (divisor == '0) zero_div_sent = zero_div_sent + 1;
    endtask

    // drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_divisions(int count);
        logic [FIELD_W-1:0] divisor;
        for (int n = 0; n < count; n++) begin
            divisor = ($urandom_range(0, 99) < 4) ? '0 : pick_operand();
            offer_division(t_op'($urandom_range(0, 3)), pick_operand(), divisor);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = OP_UQUO;
        i_dividend    = '0;
        i_divisor     = '0;
        hold_req      = 0;
        items_sent    = 0;
        zero_div_sent = 0;
        op_sent       = '{default: 0};
        tx_idle_pct   = 25;
        rx_idle_pct   = 71;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, zero divisor, signed wrap, reserved code
        offer_division(OP_UQUO, ALL_ONES, FIELD_W'(1));
        offer_division(OP_UQUO, ALL_ONES, ALL_ONES);
        offer_division(OP_UQUO, '0, ALL_ONES);
        offer_division(OP_UQUO, FIELD_W'(100), FIELD_W'(7));
        offer_division(OP_UQUO, ALL_ONES, MIN_NEG);
        offer_division(OP_UQUO, MIN_NEG, FIELD_W'(3));
        offer_division(OP_UQUO, FIELD_W'(5), '0);
        offer_division(OP_SQUO, FIELD_W'(7), '0);
        offer_division(OP_UREM, FIELD_W'(12345), '0);
        offer_division(OP_RSVD, FIELD_W'(99), '0);
        offer_division(OP_SQUO, MIN_NEG, ALL_ONES);
        offer_division(OP_SQUO, MIN_NEG, FIELD_W'(1));
        offer_division(OP_SQUO, -FIELD_W'(7), FIELD_W'(2));
        offer_division(OP_SQUO, FIELD_W'(7), -FIELD_W'(2));
        offer_division(OP_SQUO, -FIELD_W'(7), -FIELD_W'(2));
        offer_division(OP_SQUO, MAX_POS, MIN_NEG);
        offer_division(OP_SQUO, MIN_NEG, MIN_NEG);
        offer_division(OP_SQUO, ALL_ONES, ALL_ONES);
        offer_division(OP_UREM, ALL_ONES, FIELD_W'(10));
        offer_division(OP_UREM, FIELD_W'(3), FIELD_W'(7));
        offer_division(OP_UREM, ALL_ONES, MIN_NEG);
        offer_division(OP_UREM, MIN_NEG, FIELD_W'(3));
        offer_division(OP_RSVD, FIELD_W'(1000), FIELD_W'(3));

        // phase one: sender idles a quarter of the time, receiver mostly stalls
        random_divisions(RANDOM_PER_PH);
        drain_results();

        // phase two: the other way round
        tx_idle_pct = 71;
        rx_idle_pct = 25;
        random_divisions(RANDOM_PER_PH);
        drain_results();

        // phase three: no idling, opened by a long receiver hold-off so the block fills
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = hold_req + 1;
        random_divisions(RANDOM_PER_PH);
        drain_results();

        // let any stray result show up
        repeat (DATA_WIDTH + 8) @(posedge i_clk);

        $display("covered %0d items: %0d uquo, %0d squo, %0d urem, %0d reserved, %0d zero divisors",
                 items_sent, op_sent[OP_UQUO], op_sent[OP_SQUO], op_sent[OP_UREM],
                 op_sent[OP_RSVD], zero_div_sent);
        $display("three idle settings plus a %0d-cycle hold-off, %0d results compared",
                 HOLD_LEN, checked);
        if (fail_cnt == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/idiv64_pkg.sv
rtl/core/idiv64_datapath.sv
rtl/core/idiv64_ctrl.sv
rtl/core/integer_divider_64.sv
rtl/core/idiv64_chk.sv
tb/sv/integer_divider_64_check.sv
tb/sv/integer_divider_64_test.sv
